// ===== rtl/wafm_pkg.sv =====
`timescale 1ns / 1ps

package wafm_pkg;

    localparam int WIRES_PER_SET   = 8;
    localparam int COORD_FRAC_BITS = 15;
    localparam int FIELD_FRAC_BITS = 24;
    localparam int SCALE_SHIFT     = 64 - COORD_FRAC_BITS - FIELD_FRAC_BITS;

    // Configuration port
    localparam int CFG_W      = 15;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_RING_RADIUS  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIRE_CURRENT = 1'd1;
    localparam int RADIUS_W  = 15;
    localparam int CURRENT_W = 10;
    localparam logic [RADIUS_W-1:0]  RADIUS_RESET  = 15'd5898;
    localparam logic [CURRENT_W-1:0] CURRENT_RESET = 10'd400;

    // Datapath widths
    localparam int COORD_W = 16;
    localparam int ROM_W   = 32;
    localparam int POS_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int ABS_W   = 17;
    localparam int D2_W    = 2 * ABS_W + 1;
    localparam int NUM_W   = CURRENT_W + ABS_W;
    localparam int K_SPLIT = 21;
    localparam int PROD_W  = NUM_W + 2 * K_SPLIT;
    localparam int QW      = PROD_W - SCALE_SHIFT;
    localparam int FIELD_W = 32;
    localparam int MAG_W   = 31;
    localparam int SQ_W    = 64;
    localparam int SQ_STEPS = 32;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    // mu0 / (2 pi) in Q64, split into two 21-bit halves for the multipliers
    localparam longint unsigned K_MU = 64'd3689348814742;
    localparam logic [K_SPLIT-1:0] K_LO = K_SPLIT'(K_MU);
    localparam logic [K_SPLIT-1:0] K_HI = K_SPLIT'(K_MU >> K_SPLIT);

    localparam logic [FIELD_W-1:0] SAT_MAX = 32'h7fff_ffff;

    // One wire on its way through the divider cells
    typedef struct packed {
        logic            valid;
        logic            first;
        logic            last;
        logic            on;
        logic            negx;
        logic            negy;
        logic [D2_W-1:0] d2;
        logic [D2_W-1:0] remx;
        logic [QW-1:0]   qx;
        logic [D2_W-1:0] remy;
        logic [QW-1:0]   qy;
    } div_t;

    // One point on its way through the square-root cells
    typedef struct packed {
        logic               valid;
        logic               on;
        logic [FIELD_W-1:0] fx;
        logic [FIELD_W-1:0] fy;
        logic [SQ_W-1:0]    v;
        logic [SQ_W-1:0]    r;
    } sq_t;

    function automatic longint unsigned tstep(longint unsigned t, longint unsigned phi);
        return (((t * phi) >> 30) * phi) >> 30;
    endfunction

    function automatic longint taylor_sin(longint unsigned phi);
        longint unsigned t;
        longint a;
        t = phi;
        a = longint'(phi);
        t = tstep(t, phi) / 64'd6;   a = a - longint'(t);
        t = tstep(t, phi) / 64'd20;  a = a + longint'(t);
        t = tstep(t, phi) / 64'd42;  a = a - longint'(t);
        t = tstep(t, phi) / 64'd72;  a = a + longint'(t);
        t = tstep(t, phi) / 64'd110; a = a - longint'(t);
        t = tstep(t, phi) / 64'd156; a = a + longint'(t);
        t = tstep(t, phi) / 64'd210; a = a - longint'(t);
        t = tstep(t, phi) / 64'd272; a = a + longint'(t);
        t = tstep(t, phi) / 64'd342; a = a - longint'(t);
        t = tstep(t, phi) / 64'd420; a = a + longint'(t);
        return a;
    endfunction

    function automatic longint taylor_cos(longint unsigned phi);
        longint unsigned t;
        longint a;
        t = ONE_Q30;
        a = longint'(ONE_Q30);
        t = tstep(t, phi) / 64'd2;   a = a - longint'(t);
        t = tstep(t, phi) / 64'd12;  a = a + longint'(t);
        t = tstep(t, phi) / 64'd30;  a = a - longint'(t);
        t = tstep(t, phi) / 64'd56;  a = a + longint'(t);
        t = tstep(t, phi) / 64'd90;  a = a - longint'(t);
        t = tstep(t, phi) / 64'd132; a = a + longint'(t);
        t = tstep(t, phi) / 64'd182; a = a - longint'(t);
        t = tstep(t, phi) / 64'd240; a = a + longint'(t);
        t = tstep(t, phi) / 64'd306; a = a - longint'(t);
        t = tstep(t, phi) / 64'd380; a = a + longint'(t);
        return a;
    endfunction

endpackage

// ===== rtl/wafm_div_cell.sv =====
`timescale 1ns / 1ps

module wafm_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  wafm_pkg::div_t din,
    output wafm_pkg::div_t dout
);

    wafm_pkg::div_t cell_reg;
    wafm_pkg::div_t cell_next;
    logic [wafm_pkg::D2_W:0] tx;
    logic [wafm_pkg::D2_W:0] ty;
    logic [wafm_pkg::D2_W:0] dd;

    // One restoring step on both lanes; the dividend shifts out of q as the
    // quotient bits shift in.
    always_comb begin
        cell_next = din;
        dd = {1'b0, din.d2};
        tx = {din.remx, din.qx[wafm_pkg::QW-1]};
        ty = {din.remy, din.qy[wafm_pkg::QW-1]};
        if (tx >= dd) begin
            cell_next.remx = wafm_pkg::D2_W'(tx - dd);
            cell_next.qx = {din.qx[wafm_pkg::QW-2:0], 1'b1};
        end else begin
            cell_next.remx = wafm_pkg::D2_W'(tx);
            cell_next.qx = {din.qx[wafm_pkg::QW-2:0], 1'b0};
        end
        if (ty >= dd) begin
            cell_next.remy = wafm_pkg::D2_W'(ty - dd);
            cell_next.qy = {din.qy[wafm_pkg::QW-2:0], 1'b1};
        end else begin
            cell_next.remy = wafm_pkg::D2_W'(ty);
            cell_next.qy = {din.qy[wafm_pkg::QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ===== rtl/wafm_sqrt_cell.sv =====
`timescale 1ns / 1ps

module wafm_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  wafm_pkg::sq_t din,
    output wafm_pkg::sq_t dout
);

    localparam logic [wafm_pkg::SQ_W-1:0] BIT_V =
        wafm_pkg::SQ_W'(1) << (wafm_pkg::SQ_W - 2 - 2 * STEP);

    wafm_pkg::sq_t cell_reg;
    wafm_pkg::sq_t cell_next;
    logic [wafm_pkg::SQ_W-1:0] trial;

    always_comb begin
        cell_next = din;
        trial = din.r + BIT_V;
        if (din.v >= trial) begin
            cell_next.v = din.v - trial;
            cell_next.r = (din.r >> 1) + BIT_V;
        end else begin
            cell_next.r = din.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ===== rtl/wire_array_field_magnitude.sv =====
`timescale 1ns / 1ps

// Throughput: the wire sequencer feeds one wire per cycle into the divider cell row
//   while the pipeline is not stalled, so the wire count sets the rate.
// Path: from acceptance to m_tvalid an item passes the wire sequencer, 44 divider
//   cells, 32 square-root cells and the stages around them.
// Reset: aresetn is synchronous and active low; it empties the pipeline and loads
//   ring_radius = 5898 and wire_current = 400.
module wire_array_field_magnitude #(
    parameter int WIRES_PER_SET = wafm_pkg::WIRES_PER_SET
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // point_x, point_y
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [95:0]                     m_tdata,  // field_x, field_y, field_magnitude
    output logic                            m_tuser,  // on_wire
    input  logic                            cfg_wr_en,
    input  logic [wafm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wafm_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int WIRE_CNT = 2 * WIRES_PER_SET;
    localparam int K_W = $clog2(WIRE_CNT);
    localparam logic [K_W-1:0] K_LAST = K_W'(WIRE_CNT - 1);
    localparam int QW = wafm_pkg::QW;
    localparam int ACC_W = QW + K_W + 2;
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);

    // ---------------- configuration ----------------
    logic [wafm_pkg::RADIUS_W-1:0]  radius_reg;
    logic [wafm_pkg::CURRENT_W-1:0] current_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= wafm_pkg::RADIUS_RESET;
            current_reg <= wafm_pkg::CURRENT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                wafm_pkg::REG_RING_RADIUS: begin
                    radius_reg <= cfg_wdata[wafm_pkg::RADIUS_W-1:0];
                end
                wafm_pkg::REG_WIRE_CURRENT: begin
                    current_reg <= cfg_wdata[wafm_pkg::CURRENT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- wire angle table ----------------
    logic signed [wafm_pkg::ROM_W-1:0] rom_cos [WIRE_CNT];
    logic signed [wafm_pkg::ROM_W-1:0] rom_sin [WIRE_CNT];

    for (genvar g = 0; g < WIRE_CNT; g++) begin : g_rom
        localparam longint unsigned QD  = (4 * g) / WIRE_CNT;
        localparam longint unsigned RS  = 4 * g - QD * WIRE_CNT;
        localparam longint unsigned PHI = (wafm_pkg::PI_Q30 * RS) / (2 * WIRE_CNT);
        localparam longint SV = wafm_pkg::taylor_sin(PHI);
        localparam longint CV = wafm_pkg::taylor_cos(PHI);
        localparam logic signed [wafm_pkg::ROM_W-1:0] COS_V =
            wafm_pkg::ROM_W'((QD == 0) ? CV : (QD == 1) ? -SV : (QD == 2) ? -CV : SV);
        localparam logic signed [wafm_pkg::ROM_W-1:0] SIN_V =
            wafm_pkg::ROM_W'((QD == 0) ? SV : (QD == 1) ? CV : (QD == 2) ? -SV : -CV);
        assign rom_cos[g] = COS_V;
        assign rom_sin[g] = SIN_V;
    end

    // ---------------- flow control ----------------
    wafm_pkg::sq_t sq_chain [wafm_pkg::SQ_STEPS+1];
    logic m_tvalid_reg;
    logic adv;

    // The pipeline moves unless a finished result would run into a held one.
    assign adv = !(m_tvalid_reg && !m_tready && sq_chain[wafm_pkg::SQ_STEPS].valid);

    // ---------------- wire sequencer ----------------
    logic busy_reg;
    logic [K_W-1:0] k_reg;
    logic signed [wafm_pkg::COORD_W-1:0] px_reg;
    logic signed [wafm_pkg::COORD_W-1:0] py_reg;
    logic accept;

    assign s_tready = adv && (!busy_reg || k_reg == K_LAST);
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end else if (adv) begin
            if (accept) begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end else if (busy_reg) begin
                if (k_reg == K_LAST) begin
                    busy_reg <= 1'b0;
                end else begin
                    k_reg <= k_reg + K_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg <= $signed(s_tdata[15:0]);
            py_reg <= $signed(s_tdata[31:16]);
        end
    end

    // ---------------- stage 1: wire position ----------------
    logic signed [wafm_pkg::ROM_W-1:0] c_val;
    logic signed [wafm_pkg::ROM_W-1:0] s_val;
    logic [wafm_pkg::ROM_W-2:0] c_abs;
    logic [wafm_pkg::ROM_W-2:0] s_abs;
    logic [wafm_pkg::ROM_W-2+wafm_pkg::RADIUS_W:0] c_prod;
    logic [wafm_pkg::ROM_W-2+wafm_pkg::RADIUS_W:0] s_prod;
    logic [wafm_pkg::POS_W-2:0] c_mag;
    logic [wafm_pkg::POS_W-2:0] s_mag;
    logic signed [wafm_pkg::POS_W-1:0] wx_next;
    logic signed [wafm_pkg::POS_W-1:0] wy_next;

    always_comb begin
        c_val = rom_cos[k_reg];
        s_val = rom_sin[k_reg];
        c_abs = (wafm_pkg::ROM_W-1)'(c_val[wafm_pkg::ROM_W-1] ? -c_val : c_val);
        s_abs = (wafm_pkg::ROM_W-1)'(s_val[wafm_pkg::ROM_W-1] ? -s_val : s_val);
        c_prod = c_abs * radius_reg;
        s_prod = s_abs * radius_reg;
        // Round half away from zero on the magnitude.
        c_mag = (wafm_pkg::POS_W-1)'((c_prod + (1 << 29)) >> 30);
        s_mag = (wafm_pkg::POS_W-1)'((s_prod + (1 << 29)) >> 30);
        wx_next = c_val[wafm_pkg::ROM_W-1] ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
        wy_next = s_val[wafm_pkg::ROM_W-1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    end

    logic s1_valid_reg;
    logic s1_first_reg;
    logic s1_last_reg;
    logic s1_odd_reg;
    logic signed [wafm_pkg::COORD_W-1:0] s1_px_reg;
    logic signed [wafm_pkg::COORD_W-1:0] s1_py_reg;
    logic signed [wafm_pkg::POS_W-1:0] s1_wx_reg;
    logic signed [wafm_pkg::POS_W-1:0] s1_wy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_first_reg <= (k_reg == '0);
            s1_last_reg  <= (k_reg == K_LAST);
            s1_odd_reg   <= k_reg[0];
            s1_px_reg    <= px_reg;
            s1_py_reg    <= py_reg;
            s1_wx_reg    <= wx_next;
            s1_wy_reg    <= wy_next;
        end
    end

    // ---------------- stage 2: offset from the wire ----------------
    logic signed [wafm_pkg::DIFF_W-1:0] dx;
    logic signed [wafm_pkg::DIFF_W-1:0] dy;

    assign dx = wafm_pkg::DIFF_W'(s1_px_reg) - wafm_pkg::DIFF_W'(s1_wx_reg);
    assign dy = wafm_pkg::DIFF_W'(s1_py_reg) - wafm_pkg::DIFF_W'(s1_wy_reg);

    logic s2_valid_reg;
    logic s2_first_reg;
    logic s2_last_reg;
    logic s2_negx_reg;
    logic s2_negy_reg;
    logic [wafm_pkg::ABS_W-1:0] s2_adx_reg;
    logic [wafm_pkg::ABS_W-1:0] s2_ady_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            // Field direction is (-dy, dx); the offset set carries negative current.
            s2_negx_reg  <= (dy > 0) ^ s1_odd_reg;
            s2_negy_reg  <= (dx < 0) ^ s1_odd_reg;
            s2_adx_reg   <= wafm_pkg::ABS_W'(dx[wafm_pkg::DIFF_W-1] ? -dx : dx);
            s2_ady_reg   <= wafm_pkg::ABS_W'(dy[wafm_pkg::DIFF_W-1] ? -dy : dy);
        end
    end

    // ---------------- stage 3: squared distance and numerators ----------------
    logic s3_valid_reg;
    logic s3_first_reg;
    logic s3_last_reg;
    logic s3_negx_reg;
    logic s3_negy_reg;
    logic [wafm_pkg::D2_W-1:0] s3_d2_reg;
    logic [wafm_pkg::NUM_W-1:0] s3_nx_reg;
    logic [wafm_pkg::NUM_W-1:0] s3_ny_reg;
    logic [2*wafm_pkg::ABS_W-1:0] sqx;
    logic [2*wafm_pkg::ABS_W-1:0] sqy;

    assign sqx = s2_adx_reg * s2_adx_reg;
    assign sqy = s2_ady_reg * s2_ady_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_first_reg <= s2_first_reg;
            s3_last_reg  <= s2_last_reg;
            s3_negx_reg  <= s2_negx_reg;
            s3_negy_reg  <= s2_negy_reg;
            s3_d2_reg    <= wafm_pkg::D2_W'(sqx) + wafm_pkg::D2_W'(sqy);
            s3_nx_reg    <= current_reg * s2_ady_reg;
            s3_ny_reg    <= current_reg * s2_adx_reg;
        end
    end

    // ---------------- stage 4: partial products with the field constant ----------------
    localparam int PP_W = wafm_pkg::NUM_W + wafm_pkg::K_SPLIT;

    logic s4_valid_reg;
    logic s4_first_reg;
    logic s4_last_reg;
    logic s4_negx_reg;
    logic s4_negy_reg;
    logic s4_on_reg;
    logic [wafm_pkg::D2_W-1:0] s4_d2_reg;
    logic [PP_W-1:0] s4_xh_reg;
    logic [PP_W-1:0] s4_xl_reg;
    logic [PP_W-1:0] s4_yh_reg;
    logic [PP_W-1:0] s4_yl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_first_reg <= s3_first_reg;
            s4_last_reg  <= s3_last_reg;
            s4_negx_reg  <= s3_negx_reg;
            s4_negy_reg  <= s3_negy_reg;
            s4_on_reg    <= (s3_d2_reg == '0);
            s4_d2_reg    <= s3_d2_reg;
            s4_xh_reg    <= s3_nx_reg * wafm_pkg::K_HI;
            s4_xl_reg    <= s3_nx_reg * wafm_pkg::K_LO;
            s4_yh_reg    <= s3_ny_reg * wafm_pkg::K_HI;
            s4_yl_reg    <= s3_ny_reg * wafm_pkg::K_LO;
        end
    end

    // ---------------- stage 5: load the divider row ----------------
    logic [wafm_pkg::PROD_W-1:0] prod_x;
    logic [wafm_pkg::PROD_W-1:0] prod_y;
    wafm_pkg::div_t div_next;
    wafm_pkg::div_t div_chain [QW+1];
    wafm_pkg::div_t s5_reg;

    always_comb begin
        prod_x = {s4_xh_reg, {wafm_pkg::K_SPLIT{1'b0}}} + wafm_pkg::PROD_W'(s4_xl_reg);
        prod_y = {s4_yh_reg, {wafm_pkg::K_SPLIT{1'b0}}} + wafm_pkg::PROD_W'(s4_yl_reg);
        div_next.valid = s4_valid_reg;
        div_next.first = s4_first_reg;
        div_next.last  = s4_last_reg;
        div_next.on    = s4_on_reg;
        div_next.negx  = s4_negx_reg;
        div_next.negy  = s4_negy_reg;
        div_next.remx  = '0;
        div_next.remy  = '0;
        // A point on the wire contributes nothing; give the divider a harmless job.
        if (s4_on_reg) begin
            div_next.d2 = wafm_pkg::D2_W'(1);
            div_next.qx = '0;
            div_next.qy = '0;
        end else begin
            div_next.d2 = s4_d2_reg;
            div_next.qx = prod_x[wafm_pkg::PROD_W-1:wafm_pkg::SCALE_SHIFT];
            div_next.qy = prod_y[wafm_pkg::PROD_W-1:wafm_pkg::SCALE_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_reg.valid <= 1'b0;
        end else if (adv) begin
            s5_reg <= div_next;
        end
    end

    assign div_chain[0] = s5_reg;

    for (genvar i = 0; i < QW; i++) begin : g_div
        wafm_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .din     (div_chain[i]),
            .dout    (div_chain[i+1])
        );
    end

    // ---------------- signed terms ----------------
    logic t_valid_reg;
    logic t_first_reg;
    logic t_last_reg;
    logic t_on_reg;
    logic signed [QW:0] t_x_reg;
    logic signed [QW:0] t_y_reg;
    logic signed [QW:0] qx_s;
    logic signed [QW:0] qy_s;

    assign qx_s = $signed({1'b0, div_chain[QW].qx});
    assign qy_s = $signed({1'b0, div_chain[QW].qy});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
        end else if (adv) begin
            t_valid_reg <= div_chain[QW].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_first_reg <= div_chain[QW].first;
            t_last_reg  <= div_chain[QW].last;
            t_on_reg    <= div_chain[QW].on;
            t_x_reg     <= div_chain[QW].negx ? -qx_s : qx_s;
            t_y_reg     <= div_chain[QW].negy ? -qy_s : qy_s;
        end
    end

    // ---------------- accumulation over the wires ----------------
    logic signed [ACC_W-1:0] acc_x_reg;
    logic signed [ACC_W-1:0] acc_y_reg;
    logic acc_on_reg;
    logic signed [ACC_W-1:0] sum_x;
    logic signed [ACC_W-1:0] sum_y;
    logic sum_on;

    always_comb begin
        if (t_first_reg) begin
            sum_x  = ACC_W'(t_x_reg);
            sum_y  = ACC_W'(t_y_reg);
            sum_on = t_on_reg;
        end else begin
            sum_x  = acc_x_reg + ACC_W'(t_x_reg);
            sum_y  = acc_y_reg + ACC_W'(t_y_reg);
            sum_on = acc_on_reg | t_on_reg;
        end
    end

    logic a_valid_reg;
    logic signed [ACC_W-1:0] a_x_reg;
    logic signed [ACC_W-1:0] a_y_reg;
    logic a_on_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= t_valid_reg && t_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && t_valid_reg) begin
            acc_x_reg  <= sum_x;
            acc_y_reg  <= sum_y;
            acc_on_reg <= sum_on;
        end
        if (adv) begin
            a_x_reg  <= sum_x;
            a_y_reg  <= sum_y;
            a_on_reg <= sum_on;
        end
    end

    // ---------------- saturation ----------------
    logic signed [wafm_pkg::FIELD_W-1:0] fx_sat;
    logic signed [wafm_pkg::FIELD_W-1:0] fy_sat;

    always_comb begin
        priority if (a_x_reg > ACC_MAX) begin
            fx_sat = wafm_pkg::FIELD_W'(ACC_MAX);
        end else if (a_x_reg < ACC_MIN) begin
            fx_sat = wafm_pkg::FIELD_W'(ACC_MIN);
        end else begin
            fx_sat = wafm_pkg::FIELD_W'(a_x_reg);
        end
        priority if (a_y_reg > ACC_MAX) begin
            fy_sat = wafm_pkg::FIELD_W'(ACC_MAX);
        end else if (a_y_reg < ACC_MIN) begin
            fy_sat = wafm_pkg::FIELD_W'(ACC_MIN);
        end else begin
            fy_sat = wafm_pkg::FIELD_W'(a_y_reg);
        end
    end

    logic b_valid_reg;
    logic b_on_reg;
    logic [wafm_pkg::FIELD_W-1:0] b_fx_reg;
    logic [wafm_pkg::FIELD_W-1:0] b_fy_reg;
    logic [wafm_pkg::FIELD_W-1:0] b_ax_reg;
    logic [wafm_pkg::FIELD_W-1:0] b_ay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_on_reg <= a_on_reg;
            b_fx_reg <= fx_sat;
            b_fy_reg <= fy_sat;
            b_ax_reg <= wafm_pkg::FIELD_W'(fx_sat[wafm_pkg::FIELD_W-1] ? -fx_sat : fx_sat);
            b_ay_reg <= wafm_pkg::FIELD_W'(fy_sat[wafm_pkg::FIELD_W-1] ? -fy_sat : fy_sat);
        end
    end

    // ---------------- squares and their sum ----------------
    logic c_valid_reg;
    logic c_on_reg;
    logic [wafm_pkg::FIELD_W-1:0] c_fx_reg;
    logic [wafm_pkg::FIELD_W-1:0] c_fy_reg;
    logic [wafm_pkg::SQ_W-1:0] c_sx_reg;
    logic [wafm_pkg::SQ_W-1:0] c_sy_reg;
    wafm_pkg::sq_t d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_reg.valid <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
            d_reg.valid <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_on_reg <= b_on_reg;
            c_fx_reg <= b_fx_reg;
            c_fy_reg <= b_fy_reg;
            c_sx_reg <= b_ax_reg * b_ax_reg;
            c_sy_reg <= b_ay_reg * b_ay_reg;
            d_reg.on <= c_on_reg;
            d_reg.fx <= c_fx_reg;
            d_reg.fy <= c_fy_reg;
            d_reg.v  <= c_sx_reg + c_sy_reg;
            d_reg.r  <= '0;
        end
    end

    assign sq_chain[0] = d_reg;

    for (genvar j = 0; j < wafm_pkg::SQ_STEPS; j++) begin : g_sqrt
        wafm_sqrt_cell #(
            .STEP (j)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .din     (sq_chain[j]),
            .dout    (sq_chain[j+1])
        );
    end

    // ---------------- output register ----------------
    wafm_pkg::sq_t sq_fin;
    logic [wafm_pkg::MAG_W-1:0] mag;
    logic [95:0] m_tdata_reg;
    logic m_tuser_reg;

    assign sq_fin = sq_chain[wafm_pkg::SQ_STEPS];
    assign mag = (sq_fin.r > wafm_pkg::SQ_W'(wafm_pkg::SAT_MAX))
               ? wafm_pkg::MAG_W'(wafm_pkg::SAT_MAX) : sq_fin.r[wafm_pkg::MAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv && sq_fin.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && sq_fin.valid) begin
            m_tuser_reg <= sq_fin.on;
            if (sq_fin.on) begin
                m_tdata_reg <= {1'b0, wafm_pkg::MAG_W'(wafm_pkg::SAT_MAX),
                                wafm_pkg::SAT_MAX, wafm_pkg::SAT_MAX};
            end else begin
                m_tdata_reg <= {1'b0, mag, sq_fin.fy, sq_fin.fx};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // A held result stalls the whole row, so the divider output must not move.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(div_chain[QW]))
        else $error("divider row moved while the pipeline was stalled");

    // The sequencer goes idle after the last wire unless a new item came in.
    a_seq_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && k_reg == K_LAST && adv && !accept) |=> !busy_reg)
        else $error("wire sequencer did not finish its item");

    // An on-wire result always carries saturated fields.
    a_on_wire_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[31:0] == wafm_pkg::SAT_MAX &&
                                   m_tdata[63:32] == wafm_pkg::SAT_MAX))
        else $error("on-wire result without saturated fields");
`endif

endmodule

// ===== tb/tb_wire_array_field_magnitude.sv =====
`timescale 1ns / 1ps

module tb_wire_array_field_magnitude;
    import wafm_pkg::*;

    localparam int NWIRES = 2 * WIRES_PER_SET;
    localparam longint unsigned TERM_CAP = 64'd1 << 56;

    typedef struct {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [30:0] mag;
        logic        on;
    } field_t;

    typedef struct {
        logic [14:0]        rad;
        logic [9:0]         cur;
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 typed;
        field_t             res;
    } point_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    wire_array_field_magnitude uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    longint      cos_q30 [NWIRES];
    longint      sin_q30 [NWIRES];
    logic [14:0] radius_now = RADIUS_RESET;
    logic [9:0]  current_now = CURRENT_RESET;

    field_t     field_q[$];
    point_row_t rows[$];
    int         mismatches = 0;
    bit         idle_on = 1'b1;
    bit         hold_req = 1'b0;
    int         hold_cnt = 0;

    function automatic void taylor(longint unsigned phi, output longint s, output longint c);
        longint unsigned ts, tc;
        longint as_, ac;
        ts = phi;
        tc = 64'd1073741824;
        as_ = longint'(phi);
        ac = 64'd1073741824;
        for (longint unsigned n = 1; n <= 10; n++) begin
            ts = (((ts * phi) >> 30) * phi) >> 30;
            ts = ts / ((2 * n) * (2 * n + 1));
            tc = (((tc * phi) >> 30) * phi) >> 30;
            tc = tc / ((2 * n - 1) * (2 * n));
            if (n[0]) begin
                as_ -= longint'(ts);
                ac -= longint'(tc);
            end else begin
                as_ += longint'(ts);
                ac += longint'(tc);
            end
        end
        s = as_;
        c = ac;
    endfunction

    task automatic build_angle_table();
        longint unsigned q, r, phi;
        longint s, c;
        for (int k = 0; k < NWIRES; k++) begin
            q = (4 * k) / NWIRES;
            r = 4 * k - q * NWIRES;
            phi = (64'd3373259426 * r) / (2 * NWIRES);
            taylor(phi, s, c);
            case (q & 3)
                0: begin cos_q30[k] = c;  sin_q30[k] = s;  end
                1: begin cos_q30[k] = -s; sin_q30[k] = c;  end
                2: begin cos_q30[k] = -c; sin_q30[k] = -s; end
                default: begin cos_q30[k] = s; sin_q30[k] = -c; end
            endcase
        end
    endtask

    function automatic longint scale_to_radius(logic [14:0] rad, longint v);
        longint unsigned m;
        m = longint'(v < 0 ? -v : v) * rad;
        m = (m + (64'd1 << 29)) >> 30;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned wire_component(longint unsigned n, longint unsigned d2);
        logic [127:0] prod, quo;
        prod = 128'(K_MU) * 128'(n);
        quo = (prod / 128'(d2)) >> SCALE_SHIFT;
        if (quo > 128'(TERM_CAP)) return TERM_CAP;
        return quo[63:0];
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat_field(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic field_t ring_field(logic signed [15:0] px, logic signed [15:0] py);
        field_t res;
        longint sx, sy, dx, dy, bx, by, fx, fy;
        longint unsigned adx, ady, d2, ax, ay, mag;
        bit hit;
        sx = 0;
        sy = 0;
        hit = 0;
        for (int k = 0; k < NWIRES; k++) begin
            dx = longint'(px) - scale_to_radius(radius_now, cos_q30[k]);
            dy = longint'(py) - scale_to_radius(radius_now, sin_q30[k]);
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            d2 = adx * adx + ady * ady;
            if (d2 == 0) begin
                hit = 1;
            end else begin
                bx = wire_component(current_now * ady, d2);
                by = wire_component(current_now * adx, d2);
                if (dy > 0) bx = -bx;
                if (dx < 0) by = -by;
                if (k % 2 == 1) begin
                    bx = -bx;
                    by = -by;
                end
                sx += bx;
                sy += by;
            end
        end
        if (hit) begin
            res.fx = SAT_MAX;
            res.fy = SAT_MAX;
            res.mag = 31'h7fff_ffff;
            res.on = 1'b1;
        end else begin
            fx = sat_field(sx);
            fy = sat_field(sy);
            ax = fx < 0 ? -fx : fx;
            ay = fy < 0 ? -fy : fy;
            mag = floor_sqrt(ax * ax + ay * ay);
            if (mag > 64'd2147483647) mag = 64'd2147483647;
            res.fx = fx[31:0];
            res.fy = fy[31:0];
            res.mag = mag[30:0];
            res.on = 1'b0;
        end
        return res;
    endfunction

    task automatic add_row(logic [14:0] rad, logic [9:0] cur, int x, int y, bit typed,
                           logic [31:0] fx, logic [31:0] fy, logic [30:0] mag, logic on);
        point_row_t r;
        r.rad = rad;
        r.cur = cur;
        r.x = 16'(x);
        r.y = 16'(y);
        r.typed = typed;
        r.res.fx = fx;
        r.res.fy = fy;
        r.res.mag = mag;
        r.res.on = on;
        rows = {rows, r};
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (field_q.size() != 0) @(posedge aclk);
        // The pipeline is deep; let it empty fully before touching registers.
        repeat (140) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_RING_RADIUS) radius_now = val;
        else current_now = val[9:0];
    endtask

    task automatic set_ring(logic [14:0] rad, logic [9:0] cur);
        wait_drained();
        write_reg(REG_RING_RADIUS, rad);
        write_reg(REG_WIRE_CURRENT, {5'd0, cur});
    endtask

    // Drives one item; s_tvalid stays high after acceptance until the next call.
    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit typed,
                              field_t typed_res);
        field_t want;
        @(negedge aclk);
        while (idle_on && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        do @(posedge aclk); while (!s_tready);
        want = typed ? typed_res : ring_field(x, y);
        field_q = {field_q, want};
    endtask

    function automatic logic signed [15:0] pick_coord();
        int e;
        e = $urandom_range(4);
        case (e)
            0: return 16'sh8000;
            1: return 16'shffff;
            2: return 16'sh0000;
            3: return 16'sh0001;
            default: return 16'sh7fff;
        endcase
    endfunction

    task automatic random_point(output logic signed [15:0] x, output logic signed [15:0] y);
        int sel, k;
        longint wx, wy;
        sel = $urandom_range(99);
        k = $urandom_range(NWIRES - 1);
        wx = scale_to_radius(radius_now, cos_q30[k]);
        wy = scale_to_radius(radius_now, sin_q30[k]);
        if (sel < 10) begin
            x = 16'(wx);
            y = 16'(wy);
        end else if (sel < 40) begin
            x = 16'(wx + longint'($urandom_range(6)) - 3);
            y = 16'(wy + longint'($urandom_range(6)) - 3);
        end else if (sel < 50) begin
            x = pick_coord();
            y = pick_coord();
        end else begin
            x = 16'($urandom());
            y = 16'($urandom());
        end
    endtask

    initial begin
        field_t dummy;
        logic signed [15:0] px, py;
        logic [14:0] rad_list[7];
        logic [9:0]  cur_list[7];
        dummy = '{default: '0};
        build_angle_table();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset setting, then a zero ring, no current, and the largest ring.
        add_row(RADIUS_RESET, CURRENT_RESET, 0, 0, 0, 0, 0, 0, 0);
        add_row(RADIUS_RESET, CURRENT_RESET, 5898, 0, 1, SAT_MAX, SAT_MAX, 31'h7fffffff, 1);
        add_row(RADIUS_RESET, CURRENT_RESET, 0, 5898, 1, SAT_MAX, SAT_MAX, 31'h7fffffff, 1);
        add_row(RADIUS_RESET, CURRENT_RESET, -5898, 0, 1, SAT_MAX, SAT_MAX, 31'h7fffffff, 1);
        add_row(RADIUS_RESET, CURRENT_RESET, 5897, 0, 0, 0, 0, 0, 0);
        add_row(RADIUS_RESET, CURRENT_RESET, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(RADIUS_RESET, CURRENT_RESET, -32768, -32768, 0, 0, 0, 0, 0);
        add_row(RADIUS_RESET, CURRENT_RESET, 32767, -32768, 0, 0, 0, 0, 0);
        add_row(RADIUS_RESET, CURRENT_RESET, -32768, 32767, 0, 0, 0, 0, 0);
        add_row(0, CURRENT_RESET, 0, 0, 1, SAT_MAX, SAT_MAX, 31'h7fffffff, 1);
        add_row(0, CURRENT_RESET, 100, -7, 1, 0, 0, 0, 0);
        add_row(0, CURRENT_RESET, -32768, 32767, 1, 0, 0, 0, 0);
        add_row(RADIUS_RESET, 0, 123, 456, 1, 0, 0, 0, 0);
        add_row(RADIUS_RESET, 0, 5898, 0, 1, SAT_MAX, SAT_MAX, 31'h7fffffff, 1);
        add_row(32767, 1023, 32767, 0, 1, SAT_MAX, SAT_MAX, 31'h7fffffff, 1);
        add_row(32767, 1023, 32766, 0, 0, 0, 0, 0, 0);
        add_row(32767, 1023, 0, 0, 0, 0, 0, 0, 0);
        add_row(32767, 1023, 1, -1, 0, 0, 0, 0, 0);

        foreach (rows[i]) begin
            if (rows[i].rad != radius_now || rows[i].cur != current_now)
                set_ring(rows[i].rad, rows[i].cur);
            send_point(rows[i].x, rows[i].y, rows[i].typed, rows[i].res);
        end

        rad_list = '{15'd32767, 15'd0, 15'd1, 15'($urandom()), 15'($urandom()),
                     15'd5898, 15'($urandom())};
        cur_list = '{10'd1023, 10'd500, 10'd1, 10'd0, 10'($urandom()),
                     10'($urandom()), 10'($urandom())};
        for (int p = 0; p < 7; p++) begin
            set_ring(rad_list[p], cur_list[p]);
            idle_on = (p != 2);
            if (p == 1) hold_req = 1'b1;
            for (int i = 0; i < 62; i++) begin
                if (p == 3 && i == 30) begin
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    while (field_q.size() != 0) @(posedge aclk);
                end
                random_point(px, py);
                send_point(px, py, 0, dummy);
            end
        end
        idle_on = 1'b1;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (field_q.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (mismatches == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 500;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 36);
            end
        end
    end

    always @(posedge aclk) begin
        field_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (field_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item %h", m_tdata);
            end else begin
                want = field_q.pop_front();
                if (m_tdata[31:0] !== want.fx || m_tdata[63:32] !== want.fy ||
                    m_tdata[94:64] !== want.mag || m_tuser !== want.on) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "Mismatch: expected fx=%h fy=%h mag=%h on=%b, got fx=%h fy=%h mag=%h on=%b",
                            want.fx, want.fy, want.mag, want.on, m_tdata[31:0],
                            m_tdata[63:32], m_tdata[94:64], m_tuser);
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== wire_array_field_magnitude.f =====
rtl/wafm_pkg.sv
rtl/wafm_div_cell.sv
rtl/wafm_sqrt_cell.sv
rtl/wire_array_field_magnitude.sv
tb/tb_wire_array_field_magnitude.sv
